### rtl/tasg_pkg.sv
`default_nettype none

package tasg_pkg;

  localparam int ADDR_BITS = 48;

  // configuration register map
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM1      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM2      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM3      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIM4      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SWAP_MODE = 3'd4;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;

  typedef enum logic [1:0] {
    SWAP_12   = 2'd0,
    SWAP_13   = 2'd1,
    SWAP_23   = 2'd2,
    SWAP_NONE = 2'd3
  } swap_mode_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

### rtl/tasg_front.sv
`default_nettype none

module tasg_front import tasg_pkg::*; #(
  parameter int DIM_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [3:0][DIM_BITS:0]          dim_eff,
  input  wire swap_mode_t                      mode,
  input  wire logic                            in_valid,
  input  wire logic                            restart,
  input  wire logic                            queue_full,
  output logic                                 in_stall,
  output logic                                 push,
  output logic [3:0][DIM_BITS-1:0]             digits,
  output logic                                 last
);

  logic [DIM_BITS-1:0] pos [4];
  logic [DIM_BITS-1:0] pos_cur [4];
  logic [DIM_BITS-1:0] pos_next [4];
  logic [3:0]          at_end;
  logic [3:0]          carry;

  assign in_stall = queue_full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    carry[0] = 1'b1;
    for (int a = 0; a < 4; a++) begin
      pos_cur[a]  = restart ? '0 : pos[a];
      // a position at or past the last index wraps on the next advance
      at_end[a]   = {1'b0, pos_cur[a]} >= (dim_eff[a] - 1'b1);
      if (a < 3) begin
        carry[a+1] = carry[a] && at_end[a];
      end
      if (carry[a]) begin
        pos_next[a] = at_end[a] ? '0 : pos_cur[a] + 1'b1;
      end else begin
        pos_next[a] = pos_cur[a];
      end
    end
  end

  assign last = &at_end;

  // order the positions as Horner digits for the selected swap
  always_comb begin
    digits[0] = pos_cur[3];
    unique case (mode)
      SWAP_12: begin
        digits[1] = pos_cur[2];
        digits[2] = pos_cur[0];
        digits[3] = pos_cur[1];
      end
      SWAP_13: begin
        digits[1] = pos_cur[0];
        digits[2] = pos_cur[1];
        digits[3] = pos_cur[2];
      end
      SWAP_23: begin
        digits[1] = pos_cur[1];
        digits[2] = pos_cur[2];
        digits[3] = pos_cur[0];
      end
      default: begin
        digits[1] = pos_cur[2];
        digits[2] = pos_cur[1];
        digits[3] = pos_cur[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 4; a++) pos[a] <= '0;
    end else if (push) begin
      for (int a = 0; a < 4; a++) pos[a] <= pos_next[a];
    end
  end

endmodule

`default_nettype wire

### rtl/tasg_queue.sv
`default_nettype none

module tasg_queue import tasg_pkg::*; #(
  parameter int DATA_BITS = 113
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [DATA_BITS-1:0] wdata,
  input  wire logic                 pop,
  output logic [DATA_BITS-1:0]      rdata,
  output queue_status_t             qstatus
);

  logic [DATA_BITS-1:0]      mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;

  assign rdata         = mem[rd_ptr];
  assign qstatus.full  = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign qstatus.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstatus.full)
    else $error("request pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstatus.empty)
    else $error("request popped from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

### rtl/tasg_back.sv
`default_nettype none

module tasg_back import tasg_pkg::*; #(
  parameter int DIM_BITS     = 12,
  parameter int ELEMENT_BITS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [3:0][DIM_BITS:0]      dim_eff,
  input  wire swap_mode_t                  mode,
  input  wire logic                        queue_empty,
  input  wire logic [3:0][DIM_BITS-1:0]    digits,
  input  wire logic [ELEMENT_BITS-1:0]     head_element,
  input  wire logic                        head_last,
  output logic                             pop,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic [ADDR_BITS-1:0]             dest_address,
  output logic [ELEMENT_BITS-1:0]          moved_element,
  output logic                             tensor_last
);

  // partial address widths after each Horner step
  localparam int W1  = 2 * DIM_BITS;
  localparam int W2  = (3 * DIM_BITS > ADDR_BITS) ? ADDR_BITS : 3 * DIM_BITS;
  localparam int MW1 = 2 * DIM_BITS + 1;
  localparam int MW2 = DIM_BITS + 1 + W1;
  localparam int MW3 = DIM_BITS + 1 + W2;

  logic [DIM_BITS:0] b1, b2, b3;

  always_comb begin
    unique case (mode)
      SWAP_12: begin b1 = dim_eff[2]; b2 = dim_eff[0]; b3 = dim_eff[1]; end
      SWAP_13: begin b1 = dim_eff[0]; b2 = dim_eff[1]; b3 = dim_eff[2]; end
      SWAP_23: begin b1 = dim_eff[1]; b2 = dim_eff[2]; b3 = dim_eff[0]; end
      default: begin b1 = dim_eff[2]; b2 = dim_eff[1]; b3 = dim_eff[0]; end
    endcase
  end

  logic                    v1, v2, v3;
  logic                    en1, en2, en3;
  logic [W1-1:0]           t1;
  logic [W2-1:0]           t2;
  logic [DIM_BITS-1:0]     s1_q2, s1_q3, s2_q3;
  logic [ELEMENT_BITS-1:0] s1_elem, s2_elem;
  logic                    s1_last, s2_last;
  logic [MW1-1:0]          mul1;
  logic [MW2-1:0]          mul2;
  logic [MW3-1:0]          mul3;

  assign en3 = !v3 || !out_stall;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pop = !queue_empty && en1;

  assign mul1 = MW1'(b1) * MW1'(digits[0]);
  assign mul2 = MW2'(b2) * MW2'(t1);
  assign mul3 = MW3'(b3) * MW3'(t2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= pop;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      t1      <= W1'(mul1 + MW1'(digits[1]));
      s1_q2   <= digits[2];
      s1_q3   <= digits[3];
      s1_elem <= head_element;
      s1_last <= head_last;
    end
    if (en2) begin
      t2      <= W2'(mul2 + MW2'(s1_q2));
      s2_q3   <= s1_q3;
      s2_elem <= s1_elem;
      s2_last <= s1_last;
    end
    if (en3) begin
      dest_address  <= ADDR_BITS'(mul3 + MW3'(s2_q3));
      moved_element <= s2_elem;
      tensor_last   <= s2_last;
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

### rtl/tensor_axis_swap_address_generator.sv
// Channel   Handshake             Payload
// in        in_valid / in_stall   element, restart
// out       out_valid / out_stall dest_address, moved_element, tensor_last
// cfg       cfg_write             cfg_index, cfg_data (no read-back)
//
// One request per cycle sustained while in_stall and out_stall stay low; a
// result passes the three registered Horner multiply stages after its request is taken.
// A four-entry queue sits between the position counter and the multipliers.
// rst clears the position counter, the queue, the stage valids and the
// registers (sizes to 1, swap of axes 1 and 2).
// in_stall rises only when the queue is full; out_stall holds the last
// stage and backs up through the stages into the queue.
`default_nettype none

module tensor_axis_swap_address_generator import tasg_pkg::*; #(
  parameter int DIM_BITS     = 12,
  parameter int ELEMENT_BITS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [DIM_BITS:0]         cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [ELEMENT_BITS-1:0]   element,
  input  wire logic                      restart,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [ADDR_BITS-1:0]           dest_address,
  output logic [ELEMENT_BITS-1:0]        moved_element,
  output logic                           tensor_last
);

  localparam int DATA_BITS = 4 * DIM_BITS + 1 + ELEMENT_BITS;
  localparam logic [DIM_BITS:0] DIM_MAX = {1'b1, {DIM_BITS{1'b0}}};

  logic [3:0][DIM_BITS:0] dim_reg;
  logic [3:0][DIM_BITS:0] dim_eff;
  swap_mode_t             mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 4; a++) dim_reg[a] <= (DIM_BITS+1)'(1);
      mode <= SWAP_12;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIM1:      dim_reg[0] <= cfg_data;
        REG_DIM2:      dim_reg[1] <= cfg_data;
        REG_DIM3:      dim_reg[2] <= cfg_data;
        REG_DIM4:      dim_reg[3] <= cfg_data;
        REG_SWAP_MODE: mode <= swap_mode_t'(cfg_data[1:0]);
        default:       ;
      endcase
    end
  end

  // zero counts as one, oversize clamps to the largest axis
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      if (dim_reg[a] == '0) begin
        dim_eff[a] = (DIM_BITS+1)'(1);
      end else if (dim_reg[a] > DIM_MAX) begin
        dim_eff[a] = DIM_MAX;
      end else begin
        dim_eff[a] = dim_reg[a];
      end
    end
  end

  queue_status_t           qstatus;
  logic                    push;
  logic                    pop;
  logic [3:0][DIM_BITS-1:0] front_digits;
  logic                    front_last;
  logic [DATA_BITS-1:0]    head;
  logic [3:0][DIM_BITS-1:0] head_digits;
  logic                    head_last;
  logic [ELEMENT_BITS-1:0] head_element;

  tasg_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .dim_eff    (dim_eff),
    .mode       (mode),
    .in_valid   (in_valid),
    .restart    (restart),
    .queue_full (qstatus.full),
    .in_stall   (in_stall),
    .push       (push),
    .digits     (front_digits),
    .last       (front_last)
  );

  tasg_queue #(
    .DATA_BITS (DATA_BITS)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wdata   ({front_digits, front_last, element}),
    .pop     (pop),
    .rdata   (head),
    .qstatus (qstatus)
  );

  assign {head_digits, head_last, head_element} = head;

  tasg_back #(
    .DIM_BITS     (DIM_BITS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .dim_eff       (dim_eff),
    .mode          (mode),
    .queue_empty   (qstatus.empty),
    .digits        (head_digits),
    .head_element  (head_element),
    .head_last     (head_last),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .dest_address  (dest_address),
    .moved_element (moved_element),
    .tensor_last   (tensor_last)
  );

endmodule

`default_nettype wire
